[src/lzwe_pkg.sv]
// ----------------------------------------------------------------------------
// LZ window expander package
// Shared constants, symbol kinds and the length/distance code expansion.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    localparam int WINDOW_BYTES   = 4096;
    localparam int ADDR_W         = $clog2(WINDOW_BYTES);
    localparam int MIN_MATCH      = 3;
    localparam int LITERAL_COUNT  = 256;
    localparam int LENGTH_CODES   = 28;
    localparam int END_SYMBOL     = 284;
    localparam int DISTANCE_BASE  = 512;
    localparam int DISTANCE_CODES = 44;
    localparam int BYTE_FIELDS    = 8;
    localparam int IDX_W          = $clog2(BYTE_FIELDS);
    localparam int LEN_W          = 9;
    localparam int VAL_W          = 13;

    localparam logic [2:0] KIND_LIT  = 3'd0;
    localparam logic [2:0] KIND_LEN  = 3'd1;
    localparam logic [2:0] KIND_END  = 3'd2;
    localparam logic [2:0] KIND_DIST = 3'd3;
    localparam logic [2:0] KIND_BAD  = 3'd4;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [VAL_W-1:0] value;
    } dec_t;

    function automatic logic [VAL_W-1:0] expand_code(input logic [5:0] c,
                                                     input logic [8:0] extra);
        logic [3:0]       x;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] mask;
        logic [VAL_W-1:0] val;
        begin
            x    = c[5:2] - 4'd1;
            base = {{(VAL_W-3){1'b0}}, 1'b1, c[1:0]};
            mask = (VAL_W'(1) << x) - VAL_W'(1);
            if (c >= 6'd8)
            begin
                val = (base << x) | ({{(VAL_W-9){1'b0}}, extra} & mask);
            end
            else
            begin
                val = {{(VAL_W-6){1'b0}}, c};
            end
            return val;
        end
    endfunction

endpackage

[src/lzwe_hist_ram.sv]
// ----------------------------------------------------------------------------
// LZ window expander history memory
// Circular byte history with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lzwe_hist_ram
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [lzwe_pkg::ADDR_W-1:0] wr_addr,
    input  lzwe_pkg::byte_t            wr_data,
    input  logic                       rd_en,
    input  logic [lzwe_pkg::ADDR_W-1:0] rd_addr,
    output lzwe_pkg::byte_t            rd_data
);

    lzwe_pkg::byte_t mem [lzwe_pkg::WINDOW_BYTES];
    lzwe_pkg::byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/lzwe_sym_decode.sv]
// ----------------------------------------------------------------------------
// LZ window expander symbol decoder
// Classifies a symbol against the expected kind and expands its extra bits.
// ----------------------------------------------------------------------------
module lzwe_sym_decode
(
    input  logic           expect_dist,
    input  logic [9:0]     symbol,
    input  logic [8:0]     extra_bits,
    output lzwe_pkg::dec_t dec
);

    logic [9:0] code_full;
    logic [5:0] code;

    always_comb
    begin
        dec.kind  = lzwe_pkg::KIND_BAD;
        code_full = 10'd0;
        if (!expect_dist)
        begin
            if (symbol == 10'(lzwe_pkg::END_SYMBOL))
            begin
                dec.kind = lzwe_pkg::KIND_END;
            end
            else if (symbol < 10'(lzwe_pkg::LITERAL_COUNT))
            begin
                dec.kind = lzwe_pkg::KIND_LIT;
            end
            else if (symbol < 10'(lzwe_pkg::LITERAL_COUNT + lzwe_pkg::LENGTH_CODES))
            begin
                dec.kind  = lzwe_pkg::KIND_LEN;
                code_full = symbol - 10'(lzwe_pkg::LITERAL_COUNT);
            end
        end
        else if (symbol >= 10'(lzwe_pkg::DISTANCE_BASE) &&
                 symbol < 10'(lzwe_pkg::DISTANCE_BASE + lzwe_pkg::DISTANCE_CODES))
        begin
            dec.kind  = lzwe_pkg::KIND_DIST;
            code_full = symbol - 10'(lzwe_pkg::DISTANCE_BASE);
        end
        code      = code_full[5:0];
        dec.value = lzwe_pkg::expand_code(code, extra_bits);
    end

endmodule

[src/lz_symbol_window_expander_unit.sv]
// ----------------------------------------------------------------------------
// LZ symbol window expander
// Turns decoded literal, length and distance symbols into output bytes
// through a 4096-byte circular history, up to eight bytes per result.
// ----------------------------------------------------------------------------
// Channel   Signals                               Direction
// symbol    sym_valid, sym_stall, symbol,         in
//           extra_bits
// result    res_valid, res_stall, byte_a..byte_h, out
//           byte_count, last, end_of_stream,
//           bad_symbol
//
// A literal, end or bad symbol is accepted in ST_IDLE and emitted from ST_EMIT.
// A copy of L bytes is accepted in ST_IDLE, then visits ST_READ and ST_WRITE
// for each byte and ST_EMIT for each result of up to eight bytes, since each
// byte is read through the registered history port before it is written back.
// A length code is absorbed in ST_IDLE and produces no result.
// Reset clears the control state only; unwritten history reads as zero.
// A stalled result holds the sequencer while the next result is ready.
// ----------------------------------------------------------------------------
module lz_symbol_window_expander_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sym_valid,
    output logic       sym_stall,
    input  logic [9:0] symbol,
    input  logic [8:0] extra_bits,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] byte_a,
    output logic [7:0] byte_b,
    output logic [7:0] byte_c,
    output logic [7:0] byte_d,
    output logic [7:0] byte_e,
    output logic [7:0] byte_f,
    output logic [7:0] byte_g,
    output logic [7:0] byte_h,
    output logic [3:0] byte_count,
    output logic       last,
    output logic       end_of_stream,
    output logic       bad_symbol
);

    localparam int AW = lzwe_pkg::ADDR_W;
    localparam int NB = lzwe_pkg::BYTE_FIELDS;
    localparam int IW = lzwe_pkg::IDX_W;
    localparam int LW = lzwe_pkg::LEN_W;
    localparam int VW = lzwe_pkg::VAL_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic            wrapped_reg, wrapped_next;
    logic [LW-1:0]   pend_reg, pend_next;
    logic            expect_reg, expect_next;
    logic            done_reg, done_next;
    logic [AW-1:0]   rp_reg, rp_next;
    logic [LW-1:0]   left_reg, left_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            rvalid_reg, rvalid_next;
    lzwe_pkg::byte_t buf_reg [NB];
    lzwe_pkg::byte_t buf_next [NB];
    logic [3:0]      bcnt_reg, bcnt_next;
    logic            blast_reg, blast_next;
    logic            bbad_reg, bbad_next;
    logic            beos_reg, beos_next;

    logic            res_valid_reg, res_valid_next;
    lzwe_pkg::byte_t out_reg [NB];
    logic [3:0]      ocnt_reg;
    logic            olast_reg, oeos_reg, obad_reg;

    lzwe_pkg::dec_t  dec;
    logic            accept, out_free, load_out;
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr;
    lzwe_pkg::byte_t wr_data, rd_data, cp_byte;
    logic [VW-1:0]   len_sum, dist_val;

    lzwe_sym_decode u_dec
    (
        .expect_dist (expect_reg),
        .symbol      (symbol),
        .extra_bits  (extra_bits),
        .dec         (dec)
    );

    lzwe_hist_ram u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    assign sym_stall = (state_reg != ST_IDLE);
    assign accept    = sym_valid && !sym_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign load_out  = (state_reg == ST_EMIT) && out_free;
    assign cp_byte   = rvalid_reg ? rd_data : 8'h00;
    assign len_sum   = dec.value + VW'(lzwe_pkg::MIN_MATCH);
    assign dist_val  = dec.value + VW'(1);

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        pend_next    = pend_reg;
        expect_next  = expect_reg;
        done_next    = done_reg;
        rp_next      = rp_reg;
        left_next    = left_reg;
        idx_next     = idx_reg;
        rvalid_next  = rvalid_reg;
        buf_next     = buf_reg;
        bcnt_next    = bcnt_reg;
        blast_next   = blast_reg;
        bbad_next    = bbad_reg;
        beos_next    = beos_reg;
        wr_en        = 1'b0;
        wr_addr      = wp_reg;
        wr_data      = cp_byte;
        rd_en        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    for (int i = 0; i < NB; i++)
                    begin
                        buf_next[i] = 8'h00;
                    end
                    idx_next   = '0;
                    bcnt_next  = 4'd0;
                    blast_next = 1'b1;
                    bbad_next  = 1'b0;
                    beos_next  = done_reg;
                    if (done_reg)
                    begin
                        bbad_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        case (dec.kind)
                            lzwe_pkg::KIND_LIT:
                            begin
                                wr_en        = 1'b1;
                                wr_data      = symbol[7:0];
                                buf_next[0]  = symbol[7:0];
                                bcnt_next    = 4'd1;
                                wp_next      = wp_reg + AW'(1);
                                wrapped_next = wrapped_reg || (&wp_reg);
                                state_next   = ST_EMIT;
                            end
                            lzwe_pkg::KIND_LEN:
                            begin
                                pend_next   = (len_sum[LW-1:0] == '0) ? LW'(1)
                                                                     : len_sum[LW-1:0];
                                expect_next = 1'b1;
                            end
                            lzwe_pkg::KIND_END:
                            begin
                                done_next  = 1'b1;
                                beos_next  = 1'b1;
                                state_next = ST_EMIT;
                            end
                            lzwe_pkg::KIND_DIST:
                            begin
                                rp_next     = wp_reg - dist_val[AW-1:0];
                                left_next   = pend_reg;
                                pend_next   = '0;
                                expect_next = 1'b0;
                                state_next  = ST_READ;
                            end
                            default:
                            begin
                                bbad_next  = 1'b1;
                                state_next = ST_EMIT;
                            end
                        endcase
                    end
                end
            end
            ST_READ:
            begin
                rd_en       = 1'b1;
                rvalid_next = wrapped_reg || (rp_reg < wp_reg);
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                wr_en             = 1'b1;
                buf_next[idx_reg] = cp_byte;
                rp_next           = rp_reg + AW'(1);
                wp_next           = wp_reg + AW'(1);
                wrapped_next      = wrapped_reg || (&wp_reg);
                left_next         = left_reg - LW'(1);
                idx_next          = idx_reg + IW'(1);
                if (left_reg == LW'(1) || (&idx_reg))
                begin
                    bcnt_next  = {1'b0, idx_reg} + 4'd1;
                    blast_next = (left_reg == LW'(1));
                    bbad_next  = 1'b0;
                    beos_next  = 1'b0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    for (int i = 0; i < NB; i++)
                    begin
                        buf_next[i] = 8'h00;
                    end
                    idx_next   = '0;
                    state_next = blast_reg ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            pend_reg      <= '0;
            expect_reg    <= 1'b0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            pend_reg      <= pend_next;
            expect_reg    <= expect_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg     <= rp_next;
        left_reg   <= left_next;
        idx_reg    <= idx_next;
        rvalid_reg <= rvalid_next;
        buf_reg    <= buf_next;
        bcnt_reg   <= bcnt_next;
        blast_reg  <= blast_next;
        bbad_reg   <= bbad_next;
        beos_reg   <= beos_next;
        if (load_out)
        begin
            out_reg   <= buf_reg;
            ocnt_reg  <= bcnt_reg;
            olast_reg <= blast_reg;
            oeos_reg  <= beos_reg;
            obad_reg  <= bbad_reg;
        end
    end

    assign res_valid     = res_valid_reg;
    assign byte_a        = out_reg[0];
    assign byte_b        = out_reg[1];
    assign byte_c        = out_reg[2];
    assign byte_d        = out_reg[3];
    assign byte_e        = out_reg[4];
    assign byte_f        = out_reg[5];
    assign byte_g        = out_reg[6];
    assign byte_h        = out_reg[7];
    assign byte_count    = ocnt_reg;
    assign last          = olast_reg;
    assign end_of_stream = oeos_reg;
    assign bad_symbol    = obad_reg;

endmodule

[src/lzwe_checker.sv]
// ----------------------------------------------------------------------------
// LZ window expander port checker
// Watches the result channel of the expander over time.
// ----------------------------------------------------------------------------
module lzwe_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_stall,
    input logic [7:0] byte_a,
    input logic [3:0] byte_count,
    input logic       last,
    input logic       bad_symbol
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("Result transaction dropped while stalled.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> byte_count <= 4'd8)
        else $error("Result byte count exceeds eight.");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && byte_count == 4'd0 |-> last)
        else $error("Empty result transaction is not marked last.");

    a_bad_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && bad_symbol |-> byte_count == 4'd0 && byte_a == 8'h00)
        else $error("Bad symbol result carries bytes.");

endmodule

bind lz_symbol_window_expander_unit lzwe_checker u_lzwe_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .byte_a     (byte_a),
    .byte_count (byte_count),
    .last       (last),
    .bad_symbol (bad_symbol)
);
